/* hdl/etjq_pkg.sv */
// ----------------------------------------------------------------------------
// etjq_pkg: shared types and constants for the quintic Julia escape-time core
// Fixed-point helpers, register map, payload structs and the command/status
// bundle between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package etjq_pkg;

  // Q8.24 coordinates by default
  localparam int FRAC_BITS  = 24;
  localparam int RESOLUTION = 256;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int COUNT_W = 8;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = $signed(64'hFFFF_FFFF_8000_0000);
  localparam logic [63:0]        LO_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MAX  = 3'd1,
    REG_STEP_X = 3'd2,
    REG_STEP_Y = 3'd3,
    REG_C_REAL = 3'd4,
    REG_C_IMAG = 3'd5,
    REG_LIMIT  = 3'd6,
    REG_RADIUS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] y_max;
    logic        [30:0] step_x;
    logic        [30:0] step_y;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic        [7:0]  iteration_limit;
    logic        [6:0]  escape_radius;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_min:           -32'sd8388608,
    y_max:           32'sd8388608,
    step_x:          31'd65536,
    step_y:          31'd65536,
    c_real:          -32'sd13421773,
    c_imag:          32'sd0,
    iteration_limit: 8'd50,
    escape_radius:   7'd10
  };

  typedef struct packed {
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic [7:0] iteration_count;
    logic [7:0] gray_level;
    logic       inside_set;
  } res_t;

  // operand pairs fed to the complex multiplier
  typedef enum logic [2:0] {
    OP_INIT,   // (col,row) x (step_x,step_y)
    OP_CC,     // c x c
    OP_ZZ,     // z x z
    OP_WW,     // w x w
    OP_WZ      // w x z
  } op_sel_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_INIT,  // z <- start point
    UPD_CC,    // c2 <- c*c
    UPD_W,     // w <- complex product
    UPD_Z      // z <- c2 + w, count++
  } upd_e;

  typedef struct packed {
    logic    load_pix;
    logic    mul_en;
    op_sel_e op_sel;
    upd_e    upd;
    logic    div_start;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic below_limit;
    logic not_esc;
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_idx(input logic [7:0] v);
    logic [7:0] r;
    if (int'(v) >= RESOLUTION) begin
      r = 8'(RESOLUTION - 1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/etjq_div.sv */
// ----------------------------------------------------------------------------
// etjq_div: serial divider for the gray level
// Restoring division, one quotient bit per cycle; quotient known to fit 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module etjq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        busy_o,
  output logic [7:0]  quot_o
);
  import etjq_pkg::*;

  localparam int STEP_W = $clog2(COUNT_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [7:0]        rem_q;
  logic [7:0]        num_q;
  logic [7:0]        den_q;
  logic [7:0]        quot_q;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  assign trial = {rem_q, num_q[7]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(COUNT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[15:8];
      num_q <= dividend_i[7:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[7:0] : trial[7:0];
      num_q  <= {num_q[6:0], 1'b0};
      quot_q <= {quot_q[6:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* hdl/etjq_dp.sv */
// ----------------------------------------------------------------------------
// etjq_dp: datapath of the quintic Julia escape-time core
// Complex multiplier (four registered 32x32 products), floor/saturate sums,
// start-point and escape logic, iteration count, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module etjq_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  etjq_pkg::cfg_t   cfg_i,
  input  etjq_pkg::pix_t   pix_i,
  input  etjq_pkg::dp_cmd_t cmd_i,
  output etjq_pkg::dp_sts_t sts_o,
  output etjq_pkg::res_t   res_o
);
  import etjq_pkg::*;

  logic [7:0]         col_q, row_q;
  logic [13:0]        r2_q;
  logic [7:0]         cnt_q;
  logic signed [31:0] zr_q, zi_q, wr_q, wi_q, c2r_q, c2i_q;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q;
  res_t               res_q;

  logic signed [31:0] ar, ai, br, bi;

  // operand select
  always_comb begin
    case (cmd_i.op_sel)
      OP_INIT: begin
        ar = $signed({24'd0, col_q});
        ai = $signed({24'd0, row_q});
        br = $signed({1'b0, cfg_i.step_x});
        bi = $signed({1'b0, cfg_i.step_y});
      end
      OP_CC: begin
        ar = cfg_i.c_real;
        ai = cfg_i.c_imag;
        br = cfg_i.c_real;
        bi = cfg_i.c_imag;
      end
      OP_WW: begin
        ar = wr_q;
        ai = wi_q;
        br = wr_q;
        bi = wi_q;
      end
      OP_WZ: begin
        ar = wr_q;
        ai = wi_q;
        br = zr_q;
        bi = zi_q;
      end
      default: begin
        ar = zr_q;
        ai = zi_q;
        br = zr_q;
        bi = zi_q;
      end
    endcase
  end

  // complex product sums: each partial product floored, then saturated
  logic signed [63:0] fl0, fl1, fl2, fl3;
  logic signed [31:0] cm_re, cm_im;

  assign fl0   = p0_q >>> FRAC_BITS;
  assign fl1   = p1_q >>> FRAC_BITS;
  assign fl2   = p2_q >>> FRAC_BITS;
  assign fl3   = p3_q >>> FRAC_BITS;
  assign cm_re = sat32(fl0 - fl1);
  assign cm_im = sat32(fl2 + fl3);

  // escape test on exact |z|^2 (p0 = zr^2, p1 = zi^2)
  logic [63:0] mag2, mag_hi, lim_k;
  logic        lo_zero;

  assign mag2    = unsigned'(p0_q) + unsigned'(p1_q);
  assign mag_hi  = mag2 >> FRAC_BITS;
  assign lo_zero = (mag2 & LO_MASK) == 64'd0;
  assign lim_k   = 64'(r2_q) << FRAC_BITS;

  // start point
  logic signed [63:0] x_full, y_full;
  logic [63:0]        y_mag;
  logic               snap;
  logic signed [31:0] zi_start;

  assign x_full   = 64'(cfg_i.x_min) + p0_q;
  assign y_full   = 64'(cfg_i.y_max) - p1_q;
  assign y_mag    = (y_full < 0) ? unsigned'(-y_full) : unsigned'(y_full);
  assign snap     = {y_mag[62:0], 1'b0} < {33'd0, cfg_i.step_y};
  assign zi_start = snap ? 32'sd0 : sat32(y_full);

  logic signed [31:0] zr_add, zi_add;

  assign zr_add = sat32(64'(c2r_q) + 64'(wr_q));
  assign zi_add = sat32(64'(c2i_q) + 64'(wi_q));

  // gray level divider: 255*count / limit
  logic [15:0] dividend;
  logic [7:0]  quot;
  logic        div_busy;

  assign dividend = {cnt_q, 8'd0} - {8'd0, cnt_q};

  etjq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cfg_i.iteration_limit),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      col_q <= clamp_idx(pix_i.pixel_col);
      row_q <= clamp_idx(pix_i.pixel_row);
      r2_q  <= 14'(cfg_i.escape_radius) * 14'(cfg_i.escape_radius);
      cnt_q <= '0;
    end
    if (cmd_i.mul_en) begin
      p0_q <= ar * br;
      p1_q <= ai * bi;
      p2_q <= ar * bi;
      p3_q <= ai * br;
    end
    case (cmd_i.upd)
      UPD_INIT: begin
        zr_q <= sat32(x_full);
        zi_q <= zi_start;
      end
      UPD_CC: begin
        c2r_q <= cm_re;
        c2i_q <= cm_im;
      end
      UPD_W: begin
        wr_q <= cm_re;
        wi_q <= cm_im;
      end
      UPD_Z: begin
        zr_q  <= zr_add;
        zi_q  <= zi_add;
        cnt_q <= cnt_q + 8'd1;
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      res_q.iteration_count <= cnt_q;
      res_q.gray_level      <= (cfg_i.iteration_limit == 8'd0) ? 8'd0 : quot;
      res_q.inside_set      <= cnt_q == cfg_i.iteration_limit;
    end
  end

  assign sts_o.below_limit = cnt_q < cfg_i.iteration_limit;
  assign sts_o.not_esc     = (mag_hi < lim_k) || ((mag_hi == lim_k) && lo_zero);
  assign sts_o.div_busy    = div_busy;
  assign res_o             = res_q;

endmodule

`default_nettype wire

/* hdl/etjq_ctrl.sv */
// ----------------------------------------------------------------------------
// etjq_ctrl: sequencer of the quintic Julia escape-time core
// Walks start point, c*c, then z^2, z^4, z^5 and c2 + z^5 per iteration,
// then the gray division; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module etjq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  input  etjq_pkg::dp_sts_t sts_i,
  output etjq_pkg::dp_cmd_t cmd_o
);
  import etjq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_MUL,
    S_INIT_SUM,
    S_CC_SUM,
    S_LOOP,
    S_ZZ_SUM,
    S_WW_MUL,
    S_WW_SUM,
    S_WZ_MUL,
    S_WZ_SUM,
    S_ADD_C,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q;
  dp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_pix = 1'b1;
          state_d      = S_INIT_MUL;
        end
      end
      S_INIT_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.op_sel = OP_INIT;
        state_d    = S_INIT_SUM;
      end
      S_INIT_SUM: begin
        cmd.upd    = UPD_INIT;
        cmd.mul_en = 1'b1;
        cmd.op_sel = OP_CC;
        state_d    = S_CC_SUM;
      end
      S_CC_SUM: begin
        cmd.upd = UPD_CC;
        state_d = S_LOOP;
      end
      S_LOOP: begin
        if (sts_i.below_limit) begin
          cmd.mul_en = 1'b1;
          cmd.op_sel = OP_ZZ;
          state_d    = S_ZZ_SUM;
        end else begin
          state_d = S_DIV_START;
        end
      end
      S_ZZ_SUM: begin
        if (sts_i.not_esc) begin
          cmd.upd = UPD_W;
          state_d = S_WW_MUL;
        end else begin
          state_d = S_DIV_START;
        end
      end
      S_WW_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.op_sel = OP_WW;
        state_d    = S_WW_SUM;
      end
      S_WW_SUM: begin
        cmd.upd = UPD_W;
        state_d = S_WZ_MUL;
      end
      S_WZ_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.op_sel = OP_WZ;
        state_d    = S_WZ_SUM;
      end
      S_WZ_SUM: begin
        cmd.upd = UPD_W;
        state_d = S_ADD_C;
      end
      S_ADD_C: begin
        cmd.upd = UPD_Z;
        state_d = S_LOOP;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // output register free or emptying this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

/* hdl/escape_time_julia_quintic.sv */
// ----------------------------------------------------------------------------
// escape_time_julia_quintic: escape-time core for z <- c*c + z^5
// Register file on an APB-style port, sequencer and fixed-point datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) carries one pixel
//    (column, row) per transaction. The core works on one pixel at a time and
//    stalls the input from acceptance until the result is in the output reg.
//  - Output channel (out_valid_o / out_stall_i / out_data_o) returns count,
//    gray level and inside flag, one transaction per pixel, in order.
//  - From acceptance the sequencer runs the setup (start point, c*c), then
//    the iterations: z^2, z^4, z^5 through the one complex multiplier (four
//    32x32 products, registered), a multiply state and a sum state each,
//    plus the add of c*c. The tail is loop exit, the 8-step serial divide
//    for the gray level, then done.
//  - The core takes no new pixel until the previous one has reached the
//    output register.
//  - The output register decouples the sides: a new pixel is taken while the
//    previous result waits. A stalled receiver holds the result; the core
//    finishes the next pixel and then waits in its done state.
//  - Reset clears the sequencer and output valid and loads the register
//    defaults (view -0.5..0.5, c = -0.8, limit 50, radius 10).
//  - Registers may be written only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_julia_quintic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  etjq_pkg::pix_t                in_data_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output etjq_pkg::res_t                out_data_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etjq_pkg::ADDR_W-1:0]   paddr,
  input  logic [etjq_pkg::DATA_W-1:0]   pwdata,
  output logic [etjq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import etjq_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  // word address selects the register, byte offset ignored
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_X_MIN:  cfg_d.x_min           = pwdata;
        REG_Y_MAX:  cfg_d.y_max           = pwdata;
        REG_STEP_X: cfg_d.step_x          = pwdata[30:0];
        REG_STEP_Y: cfg_d.step_y          = pwdata[30:0];
        REG_C_REAL: cfg_d.c_real          = pwdata;
        REG_C_IMAG: cfg_d.c_imag          = pwdata;
        REG_LIMIT:  cfg_d.iteration_limit = pwdata[7:0];
        REG_RADIUS: cfg_d.escape_radius   = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back, unsigned fields zero-extended
  always_comb begin
    case (reg_idx)
      REG_X_MIN:  prdata = cfg_q.x_min;
      REG_Y_MAX:  prdata = cfg_q.y_max;
      REG_STEP_X: prdata = {1'b0, cfg_q.step_x};
      REG_STEP_Y: prdata = {1'b0, cfg_q.step_y};
      REG_C_REAL: prdata = cfg_q.c_real;
      REG_C_IMAG: prdata = cfg_q.c_imag;
      REG_LIMIT:  prdata = {24'd0, cfg_q.iteration_limit};
      REG_RADIUS: prdata = {25'd0, cfg_q.escape_radius};
      default:    prdata = '0;
    endcase
  end

  etjq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etjq_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* hdl/etjq_chk.sv */
// ----------------------------------------------------------------------------
// etjq_chk: port-level checks for the quintic Julia escape-time core
// Bound to the top level; watches handshakes and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module etjq_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input etjq_pkg::res_t out_data_o
);
  import etjq_pkg::*;

  // one pixel in flight: core busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // inside pixels sit at full white, or limit zero gives all zeros
  a_inside_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.inside_set) |->
      (out_data_o.gray_level == 8'd255 ||
       (out_data_o.iteration_count == 8'd0 && out_data_o.gray_level == 8'd0)))
    else $error("inside flag disagrees with gray level");

  // escaped pixels never reach full white, and gray is at least the count
  a_outside_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.inside_set) |->
      (out_data_o.gray_level != 8'd255 &&
       out_data_o.gray_level >= out_data_o.iteration_count))
    else $error("gray level out of range for escaped pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

endmodule

bind escape_time_julia_quintic etjq_chk u_chk (.*);

`default_nettype wire
